/* rtl/core/hufd_pkg.sv */
// Shared types, constants and index helpers of the Huffman tree-walk decoder.
package hufd_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned LINK_W    = 9;
  localparam int unsigned SYM_IN_W  = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SYM_OUT_W = 8;
  localparam int unsigned STAT_W    = 2;

  // Defaults of the top-level parameters
  localparam int unsigned TABLE_DEPTH_DEF = 512;
  localparam int unsigned SYMBOL_BITS_DEF = 8;

  // Input item kinds
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_DECODE = 2'd1,
    ACT_END    = 2'd2
  } action_e;

  // Result kinds
  typedef enum logic [STAT_W-1:0] {
    STAT_SYMBOL = 2'd0,
    STAT_CLEAN  = 2'd1,
    STAT_TRUNC  = 2'd2
  } status_e;

  // Reduce a link field modulo the table depth by restoring subtraction of
  // shifted copies of the depth; shifts past the field range fold away.
  function automatic logic [LINK_W-1:0] wrap_link(logic [LINK_W-1:0] v,
                                                  int unsigned depth);
    logic [LINK_W-1:0] r;
    int unsigned       step;
    r = v;
    for (int k = LINK_W - 1; k >= 0; k--) begin
      step = depth << k;
      if ((step < (32'd1 << LINK_W)) && ({23'd0, r} >= step)) begin
        r = r - LINK_W'(step);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/hufd_if.sv */
// Valid/ready channel interfaces for decoder input items and result items.
interface hufd_in_if;
  logic                             valid;
  logic                             ready;
  logic [hufd_pkg::ACT_W-1:0]       action;
  logic [hufd_pkg::LINK_W-1:0]      node_index;
  logic [hufd_pkg::LINK_W-1:0]      zero_child;
  logic [hufd_pkg::LINK_W-1:0]      one_child;
  logic                             is_leaf;
  logic [hufd_pkg::SYM_IN_W-1:0]    leaf_symbol;
  logic [hufd_pkg::BYTE_W-1:0]      data_byte;

  modport source (
    output valid, action, node_index, zero_child, one_child, is_leaf,
           leaf_symbol, data_byte,
    input  ready
  );
  modport sink (
    input  valid, action, node_index, zero_child, one_child, is_leaf,
           leaf_symbol, data_byte,
    output ready
  );
endinterface

interface hufd_out_if;
  logic                             valid;
  logic                             ready;
  logic [hufd_pkg::SYM_OUT_W-1:0]   symbol;
  logic [hufd_pkg::STAT_W-1:0]      status;
  logic                             last;

  modport source (
    output valid, symbol, status, last,
    input  ready
  );
  modport sink (
    input  valid, symbol, status, last,
    output ready
  );
endinterface

/* rtl/core/huffman_tree_bit_decoder.sv */
// Top level of the Huffman tree-walk decoder.
//
//   channel  dir  handshake          beat carries
//   in_ch    in   valid/ready        action, node_index, zero_child, one_child,
//                                    is_leaf, leaf_symbol, data_byte
//   out_ch   out  valid/ready        symbol, status, last
//   cfg      in   cfg_we_i           root_node (cfg_wdata_i)
//
// A load beat writes the node table when it is accepted. A decode beat first
// fetches the root entry if it is the first byte after reset or a root write,
// then issues one node-table read per code bit, resolves the last read and
// flushes the held symbol. An end beat emits one end result. Back-pressure on
// out_ch stalls the walk while a symbol is waiting.
// Reset clears control state only; the node table holds no value until loaded.
module huffman_tree_bit_decoder #(
  parameter int unsigned TABLE_DEPTH = hufd_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SYMBOL_BITS = hufd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hufd_in_if.sink                       in_ch,
  hufd_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [hufd_pkg::LINK_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IDX_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned ENT_W    = 2 * IDX_W + 1 + SYMBOL_BITS;
  localparam int unsigned SYM_LSB  = 0;
  localparam int unsigned LEAF_BIT = SYMBOL_BITS;
  localparam int unsigned ONE_LSB  = SYMBOL_BITS + 1;
  localparam int unsigned ZERO_LSB = ONE_LSB + IDX_W;
  localparam int unsigned CNT_W    = $clog2(hufd_pkg::BYTE_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REFETCH,
    ST_WALK,
    ST_FLUSH,
    ST_END
  } state_e;

  state_e                       state_q, state_d;
  logic [IDX_W-1:0]             cur_idx_q, cur_idx_d;
  logic [IDX_W-1:0]             root_idx_q, root_idx_d;
  logic [ENT_W-1:0]             cur_ent_q, cur_ent_d;
  logic [ENT_W-1:0]             root_ent_q, root_ent_d;
  logic                         ent_ok_q, ent_ok_d;
  logic                         pend_q, pend_d;
  logic [CNT_W-1:0]             bits_left_q, bits_left_d;
  logic [hufd_pkg::BYTE_W-1:0]  byte_q, byte_d;
  logic                         hold_vld_q, hold_vld_d;
  logic [SYMBOL_BITS-1:0]       hold_sym_q, hold_sym_d;
  hufd_pkg::status_e            end_stat_q, end_stat_d;
  logic                         out_vld_q, out_vld_d;
  logic [hufd_pkg::SYM_OUT_W-1:0] out_sym_q, out_sym_d;
  hufd_pkg::status_e            out_stat_q, out_stat_d;
  logic                         out_last_q, out_last_d;

  logic                         in_acc;
  logic                         out_free;
  logic                         ld_we;
  logic [IDX_W-1:0]             ld_idx;
  logic [ENT_W-1:0]             ld_ent;
  logic [IDX_W-1:0]             cfg_root;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic [ENT_W-1:0]             rd_data;
  logic                         leaf_now;
  logic [ENT_W-1:0]             eff_ent;
  logic [IDX_W-1:0]             eff_idx;
  logic [IDX_W-1:0]             next_idx;
  logic                         push;
  logic [hufd_pkg::SYM_OUT_W-1:0] push_sym;
  hufd_pkg::status_e            push_stat;
  logic                         push_last;

  // Handshake
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_q || out_ch.ready;

  // Load path: wrap indexes, pack the entry
  assign ld_we  = in_acc && (in_ch.action == hufd_pkg::ACT_LOAD);
  assign ld_idx = IDX_W'(hufd_pkg::wrap_link(in_ch.node_index, TABLE_DEPTH));
  assign ld_ent = {IDX_W'(hufd_pkg::wrap_link(in_ch.zero_child, TABLE_DEPTH)),
                   IDX_W'(hufd_pkg::wrap_link(in_ch.one_child, TABLE_DEPTH)),
                   in_ch.is_leaf,
                   SYMBOL_BITS'(in_ch.leaf_symbol)};
  assign cfg_root = IDX_W'(hufd_pkg::wrap_link(cfg_wdata_i, TABLE_DEPTH));

  hufd_node_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_idx),
    .wdata_i (ld_ent),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Resolve the entry of the current node: a fresh read that hit a leaf
  // sends the walk back to the cached root entry.
  assign leaf_now = pend_q && rd_data[LEAF_BIT];
  assign eff_ent  = leaf_now ? root_ent_q : (pend_q ? rd_data : cur_ent_q);
  assign eff_idx  = leaf_now ? root_idx_q : cur_idx_q;
  assign next_idx = byte_q[hufd_pkg::BYTE_W-1] ? eff_ent[ONE_LSB +: IDX_W]
                                                : eff_ent[ZERO_LSB +: IDX_W];

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    cur_idx_d   = cur_idx_q;
    root_idx_d  = root_idx_q;
    cur_ent_d   = cur_ent_q;
    root_ent_d  = root_ent_q;
    ent_ok_d    = ent_ok_q;
    pend_d      = pend_q;
    bits_left_d = bits_left_q;
    byte_d      = byte_q;
    hold_vld_d  = hold_vld_q;
    hold_sym_d  = hold_sym_q;
    end_stat_d  = end_stat_q;
    rd_en       = 1'b0;
    rd_addr     = next_idx;
    push        = 1'b0;
    push_sym    = hufd_pkg::SYM_OUT_W'(hold_sym_q);
    push_stat   = hufd_pkg::STAT_SYMBOL;
    push_last   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        // Root write moves the walk and invalidates the cached entries
        if (cfg_we_i) begin
          root_idx_d = cfg_root;
          cur_idx_d  = cfg_root;
          ent_ok_d   = 1'b0;
        end
        if (in_acc) begin
          case (in_ch.action)
            hufd_pkg::ACT_LOAD: begin
              // Forward the new entry into the cached copies
              if (ld_idx == cur_idx_q) begin
                cur_ent_d = ld_ent;
              end
              if (ld_idx == root_idx_q) begin
                root_ent_d = ld_ent;
              end
            end
            hufd_pkg::ACT_DECODE: begin
              byte_d      = in_ch.data_byte;
              bits_left_d = CNT_W'(hufd_pkg::BYTE_W);
              pend_d      = 1'b0;
              if (ent_ok_q) begin
                state_d = ST_WALK;
              end else begin
                rd_en   = 1'b1;
                rd_addr = cur_idx_q;
                state_d = ST_REFETCH;
              end
            end
            hufd_pkg::ACT_END: begin
              end_stat_d = (cur_idx_q == root_idx_q) ? hufd_pkg::STAT_CLEAN
                                                     : hufd_pkg::STAT_TRUNC;
              cur_idx_d  = root_idx_q;
              cur_ent_d  = root_ent_q;
              state_d    = ST_END;
            end
            default: begin
            end
          endcase
        end
      end

      ST_REFETCH: begin
        // Walk sits at the root here: fill both cached entries
        cur_ent_d  = rd_data;
        root_ent_d = rd_data;
        ent_ok_d   = 1'b1;
        state_d    = ST_WALK;
      end

      ST_WALK: begin
        // Stall only when a leaf needs the hold slot and the output is full
        if (!(leaf_now && hold_vld_q && !out_free)) begin
          if (leaf_now) begin
            push       = hold_vld_q;
            hold_sym_d = rd_data[SYM_LSB +: SYMBOL_BITS];
            hold_vld_d = 1'b1;
          end
          cur_ent_d = eff_ent;
          cur_idx_d = eff_idx;
          pend_d    = 1'b0;
          if (bits_left_q != '0) begin
            // Issue the read for the next bit
            rd_en       = 1'b1;
            rd_addr     = next_idx;
            cur_idx_d   = next_idx;
            pend_d      = 1'b1;
            bits_left_d = CNT_W'(bits_left_q - 1'b1);
            byte_d      = {byte_q[hufd_pkg::BYTE_W-2:0], 1'b0};
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        // Release the held symbol as the final result of the byte
        if (!hold_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      ST_END: begin
        if (out_free) begin
          push      = 1'b1;
          push_sym  = '0;
          push_stat = end_stat_q;
          push_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_vld_d  = out_vld_q;
    out_sym_d  = out_sym_q;
    out_stat_d = out_stat_q;
    out_last_d = out_last_q;
    if (push) begin
      out_vld_d  = 1'b1;
      out_sym_d  = push_sym;
      out_stat_d = push_stat;
      out_last_d = push_last;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_idx_q   <= '0;
      root_idx_q  <= '0;
      ent_ok_q    <= 1'b0;
      pend_q      <= 1'b0;
      bits_left_q <= '0;
      hold_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_idx_q   <= cur_idx_d;
      root_idx_q  <= root_idx_d;
      ent_ok_q    <= ent_ok_d;
      pend_q      <= pend_d;
      bits_left_q <= bits_left_d;
      hold_vld_q  <= hold_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_ent_q  <= cur_ent_d;
    root_ent_q <= root_ent_d;
    byte_q     <= byte_d;
    hold_sym_q <= hold_sym_d;
    end_stat_q <= end_stat_d;
    out_sym_q  <= out_sym_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  assign out_ch.valid  = out_vld_q;
  assign out_ch.symbol = out_sym_q;
  assign out_ch.status = out_stat_q;
  assign out_ch.last   = out_last_q;

endmodule

/* rtl/core/hufd_node_ram.sv */
// Node table storage: one write port, one registered read port.
module hufd_node_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 27
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read on enable, hold data otherwise
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/hufd_check.sv */
// Port-level assertions for the decoder, bound to the top level.
module hufd_check (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic [hufd_pkg::ACT_W-1:0]      in_action_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [hufd_pkg::SYM_OUT_W-1:0]  out_symbol_i,
  input logic [hufd_pkg::STAT_W-1:0]     out_status_i,
  input logic                            out_last_i
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_symbol_i) && $stable(out_status_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  // End-of-stream results close their item and carry no symbol
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != hufd_pkg::STAT_SYMBOL) |->
      out_last_i && (out_symbol_i == '0))
    else $error("end result without last or with a symbol");

  // Decode and end beats occupy the block for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
      ((in_action_i == hufd_pkg::ACT_DECODE) || (in_action_i == hufd_pkg::ACT_END))
      |=> !in_ready_i)
    else $error("input accepted while a walk is in progress");

endmodule

bind huffman_tree_bit_decoder hufd_check u_hufd_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .in_action_i  (in_ch.action),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_symbol_i (out_ch.symbol),
  .out_status_i (out_ch.status),
  .out_last_i   (out_ch.last)
);
